FILE: src/shash_pkg.sv
// SHA-256 stream hasher package: round constants, initial hash and round functions.
package shash_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned NumWords = 8;
  localparam int unsigned NumRounds = 64;
  localparam int unsigned BlockBytes = 64;
  localparam int unsigned LenW    = 64;
  localparam logic [7:0]  PadByte = 8'h80;

  localparam logic [WordW-1:0] RoundK [NumRounds] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [WordW-1:0] InitHash [NumWords] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic logic [WordW-1:0] rotr(input logic [WordW-1:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (WordW - n));
  endfunction

  function automatic logic [WordW-1:0] big_sigma0(input logic [WordW-1:0] x);
    big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [WordW-1:0] big_sigma1(input logic [WordW-1:0] x);
    big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [WordW-1:0] small_sigma0(input logic [WordW-1:0] x);
    small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [WordW-1:0] small_sigma1(input logic [WordW-1:0] x);
    small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

FILE: src/sha256_stream_hasher_unit.sv
// SHA-256 stream hasher top level: byte gathering, padding, iterative round engine, digest out.
// Each data byte is taken while idle; each full block then runs the rounds and a chaining add
// on the single shared round unit.
// End of message: padding, one or two compressions, then the eight digest words;
// in_stall_o is high throughout.
// The input stalls while a block is compressed, so no new message byte is taken until it is done.
// Reset (async, active low) loads the initial hash, clears the fill count and length.
module sha256_stream_hasher_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        byte_present_i,
  input  logic        end_of_message_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);
  import shash_pkg::*;

  localparam int unsigned BlockW = BlockBytes * 8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_FINAL,
    ST_OUT
  } state_e;

  state_e            state_q, state_d;
  logic [5:0]        rnd_q, rnd_d;
  logic [5:0]        fill_q, fill_d;
  logic [LenW-1:0]   len_q, len_d;
  logic              end_q, end_d;
  logic              pad_q, pad_d;
  logic              first_q, first_d;
  logic              lenph_q, lenph_d;
  logic [2:0]        idx_q, idx_d;
  logic [WordW-1:0]  chain_q [NumWords];
  logic [WordW-1:0]  chain_d [NumWords];

  logic [BlockW-1:0] blk_q;
  logic [WordW-1:0]  v_q [NumWords];

  logic              byte_shift;
  logic [7:0]        shift_byte;
  logic              v_load;
  logic              v_round;

  logic [LenW-1:0]   len_bits;
  logic [LenW-1:0]   len_shift;
  logic [7:0]        pad_byte;

  logic [WordW-1:0]  w0, w1, w9, w14, w_new;
  logic [WordW-1:0]  t1, t2;

  assign len_bits  = {len_q[LenW-4:0], 3'b000};
  assign len_shift = len_bits >> {3'(3'd7 - fill_q[2:0]), 3'b000};

  always_comb begin
    if (first_q) begin
      pad_byte = PadByte;
    end else if (lenph_q && (fill_q[5:3] == 3'b111)) begin
      pad_byte = len_shift[7:0];
    end else begin
      pad_byte = 8'h00;
    end
  end

  // message schedule taps on the block shift line
  assign w0    = blk_q[BlockW-1 -: WordW];
  assign w1    = blk_q[BlockW-1-WordW -: WordW];
  assign w9    = blk_q[BlockW-1-9*WordW -: WordW];
  assign w14   = blk_q[BlockW-1-14*WordW -: WordW];
  assign w_new = w0 + small_sigma0(w1) + w9 + small_sigma1(w14);

  assign t1 = v_q[7] + big_sigma1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
            + RoundK[rnd_q] + w0;
  assign t2 = big_sigma0(v_q[0])
            + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));

  always_comb begin
    state_d    = state_q;
    rnd_d      = rnd_q;
    fill_d     = fill_q;
    len_d      = len_q;
    end_d      = end_q;
    pad_d      = pad_q;
    first_d    = first_q;
    lenph_d    = lenph_q;
    idx_d      = idx_q;
    chain_d    = chain_q;
    byte_shift = 1'b0;
    shift_byte = data_byte_i;
    v_load     = 1'b0;
    v_round    = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          end_d = end_of_message_i;
          pad_d = 1'b0;
          if (byte_present_i) begin
            byte_shift = 1'b1;
            fill_d     = fill_q + 6'd1;
            len_d      = len_q + 64'd1;
          end
          if (byte_present_i && (fill_q == 6'd63)) begin
            state_d = ST_ROUND;
            rnd_d   = '0;
            v_load  = 1'b1;
          end else if (end_of_message_i) begin
            state_d = ST_PAD;
            pad_d   = 1'b1;
            first_d = 1'b1;
          end
        end
      end
      ST_PAD: begin
        byte_shift = 1'b1;
        shift_byte = pad_byte;
        fill_d     = fill_q + 6'd1;
        first_d    = 1'b0;
        if (first_q) begin
          lenph_d = (fill_q[5:3] != 3'b111);
        end
        if (fill_q == 6'd63) begin
          state_d = ST_ROUND;
          rnd_d   = '0;
          v_load  = 1'b1;
        end
      end
      ST_ROUND: begin
        v_round = 1'b1;
        rnd_d   = rnd_q + 6'd1;
        if (rnd_q == 6'd63) begin
          state_d = ST_FINAL;
        end
      end
      ST_FINAL: begin
        for (int i = 0; i < NumWords; i++) begin
          chain_d[i] = chain_q[i] + v_q[i];
        end
        if (!end_q) begin
          state_d = ST_IDLE;
        end else if (!pad_q) begin
          state_d = ST_PAD;
          pad_d   = 1'b1;
          first_d = 1'b1;
        end else if (!lenph_q) begin
          state_d = ST_PAD;
          lenph_d = 1'b1;
        end else begin
          state_d = ST_OUT;
          idx_d   = '0;
        end
      end
      ST_OUT: begin
        if (!out_stall_i) begin
          idx_d = idx_q + 3'd1;
          if (idx_q == 3'd7) begin
            state_d = ST_IDLE;
            chain_d = InitHash;
            len_d   = '0;
            fill_d  = '0;
            end_d   = 1'b0;
            pad_d   = 1'b0;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      rnd_q   <= '0;
      fill_q  <= '0;
      len_q   <= '0;
      end_q   <= 1'b0;
      pad_q   <= 1'b0;
      first_q <= 1'b0;
      lenph_q <= 1'b0;
      idx_q   <= '0;
      chain_q <= InitHash;
    end else begin
      state_q <= state_d;
      rnd_q   <= rnd_d;
      fill_q  <= fill_d;
      len_q   <= len_d;
      end_q   <= end_d;
      pad_q   <= pad_d;
      first_q <= first_d;
      lenph_q <= lenph_d;
      idx_q   <= idx_d;
      chain_q <= chain_d;
    end
  end

  // block shift line and working variables
  always_ff @(posedge clk_i) begin
    if (byte_shift) begin
      blk_q <= {blk_q[BlockW-9:0], shift_byte};
    end else if (v_round) begin
      blk_q <= {blk_q[BlockW-WordW-1:0], w_new};
    end
    if (v_load) begin
      v_q <= chain_q;
    end else if (v_round) begin
      v_q[7] <= v_q[6];
      v_q[6] <= v_q[5];
      v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2];
      v_q[2] <= v_q[1];
      v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
    end
  end

  assign in_stall_o    = (state_q != ST_IDLE);
  assign out_valid_o   = (state_q == ST_OUT);
  assign digest_word_o = chain_q[idx_q];
  assign word_index_o  = idx_q;
  assign last_word_o   = (idx_q == 3'd7);

endmodule

FILE: src/shash_checker.sv
// Port-level checker for the SHA-256 stream hasher, bound to the top level.
module shash_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        end_of_message_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] digest_word_o,
  input logic [2:0]  word_index_o,
  input logic        last_word_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(digest_word_o)
      && $stable(word_index_o))
    else $error("stalled digest transfer changed");

  a_words_continue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && (word_index_o != 3'd7) |=>
      out_valid_o && (word_index_o == $past(word_index_o) + 3'd1))
    else $error("digest words not in sequence");

  a_last_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_word_o == (word_index_o == 3'd7)))
    else $error("last_word_o does not match word index");

  a_end_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && end_of_message_i |=> in_stall_o)
    else $error("end of message did not start finishing");

  a_out_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input taken while digest pending");

endmodule

bind sha256_stream_hasher_unit shash_checker u_shash_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_stall_o       (in_stall_o),
  .end_of_message_i (end_of_message_i),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .digest_word_o    (digest_word_o),
  .word_index_o     (word_index_o),
  .last_word_o      (last_word_o)
);
